/* hdl/lrast_pkg.sv */
package lrast_pkg;

  // minor-axis move chosen by one decision step
  typedef struct packed {
    logic inc;
    logic dec;
  } lrast_move_t;

endpackage

/* hdl/line_rasterizer.sv */
// Bresenham line rasterizer. A request on the in_ channel carries two endpoints
// and a gray value; the block then emits every pixel of the line on the out_
// channel in order along the increasing major axis, with out_tlast on the final
// one. The scan is horizontal when |dx| > |dy| and vertical otherwise (diagonals
// and single points included). A request is accepted in an idle cycle and passes
// through the three setup states ST_DELTA, ST_ORIENT and ST_INIT; the line is then
// drawn at one pixel per cycle while the output is taken without stalls. A single
// decision/step unit is reused for every pixel, and in_tready is high only between
// requests.
module line_rasterizer
  import lrast_pkg::*;
#(
  parameter  int COORD_BITS = 6,
  localparam int IN_W       = ((4 * COORD_BITS + 8 + 7) / 8) * 8,
  localparam int OUT_W      = ((2 * COORD_BITS + 8 + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // start_x, start_y, end_x, end_y, gray_value
  input  logic [IN_W-1:0]       in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // pixel_x, pixel_y, pixel_gray
  output logic [OUT_W-1:0]      out_tdata,
  output logic                  out_tlast
);

  localparam int CB    = COORD_BITS;
  localparam int DW    = COORD_BITS + 4;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DELTA  = 5'b00010,
    ST_ORIENT = 5'b00100,
    ST_INIT   = 5'b01000,
    ST_RUN    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [CB-1:0] x0_r, y0_r, x1_r, y1_r;
  logic [7:0]    gray_r;
  logic signed [CB:0] dx_r, dy_r;
  logic          horiz_r;
  logic [CB-1:0] a_r, amax_r, b_r;
  logic signed [CB:0] m_r, big_r;
  logic          pos_r;
  logic signed [DW-1:0] d_r, inc_lo_r, inc_hi_r;

  logic          out_tvalid_r;
  logic [CB-1:0] pixel_x_r, pixel_y_r;
  logic [7:0]    pixel_gray_r;
  logic          last_pixel_r;

  logic in_req, load, last;
  logic signed [CB:0] adx, ady;
  logic          horiz, swap;
  logic signed [DW-1:0] m2, big2, big_e;
  logic signed [DW-1:0] d_step;
  logic [CB-1:0] a_step, b_step;
  lrast_move_t   move;

  assign in_tready = (state_r == ST_IDLE);
  assign in_req    = in_tvalid && in_tready;
  assign last      = (a_r == amax_r);
  assign load      = (state_r == ST_RUN) && (!out_tvalid_r || out_tready);

  assign adx   = dx_r[CB] ? -dx_r : dx_r;
  assign ady   = dy_r[CB] ? -dy_r : dy_r;
  assign horiz = adx > ady;
  assign swap  = horiz ? dx_r[CB] : dy_r[CB];

  assign m2    = {{(DW-CB-2){m_r[CB]}}, m_r, 1'b0};
  assign big_e = {{(DW-CB-1){big_r[CB]}}, big_r};
  assign big2  = big_e <<< 1;

  lrast_step #(
    .CW(CB),
    .DW(DW)
  ) u_step (
    .d_i      (d_r),
    .inc_lo_i (inc_lo_r),
    .inc_hi_i (inc_hi_r),
    .pos_i    (pos_r),
    .major_i  (a_r),
    .minor_i  (b_r),
    .d_o      (d_step),
    .major_o  (a_step),
    .minor_o  (b_step),
    .move_o   (move)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_req) state_nxt = ST_DELTA;
      ST_DELTA:  state_nxt = ST_ORIENT;
      ST_ORIENT: state_nxt = ST_INIT;
      ST_INIT:   state_nxt = ST_RUN;
      ST_RUN:    if (load && last) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_req) begin
      x0_r   <= in_tdata[CB-1:0];
      y0_r   <= in_tdata[2*CB-1:CB];
      x1_r   <= in_tdata[3*CB-1:2*CB];
      y1_r   <= in_tdata[4*CB-1:3*CB];
      gray_r <= in_tdata[4*CB+7:4*CB];
    end
    if (state_r == ST_DELTA) begin
      dx_r <= signed'({1'b0, x1_r}) - signed'({1'b0, x0_r});
      dy_r <= signed'({1'b0, y1_r}) - signed'({1'b0, y0_r});
    end
    if (state_r == ST_ORIENT) begin
      horiz_r <= horiz;
      if (horiz) begin
        a_r    <= swap ? x1_r : x0_r;
        amax_r <= swap ? x0_r : x1_r;
        b_r    <= swap ? y1_r : y0_r;
        m_r    <= swap ? -dy_r : dy_r;
        big_r  <= adx;
      end else begin
        a_r    <= swap ? y1_r : y0_r;
        amax_r <= swap ? y0_r : y1_r;
        b_r    <= swap ? x1_r : x0_r;
        m_r    <= swap ? -dx_r : dx_r;
        big_r  <= ady;
      end
    end
    if (state_r == ST_INIT) begin
      pos_r <= !m_r[CB];
      if (!m_r[CB]) begin
        d_r      <= m2 - big_e;
        inc_lo_r <= m2;
        inc_hi_r <= m2 - big2;
      end else begin
        d_r      <= m2 + big_e;
        inc_lo_r <= m2 + big2;
        inc_hi_r <= m2;
      end
    end
    if (load) begin
      pixel_x_r    <= horiz_r ? a_r : b_r;
      pixel_y_r    <= horiz_r ? b_r : a_r;
      pixel_gray_r <= gray_r;
      last_pixel_r <= last;
      if (!last) begin
        d_r <= d_step;
        a_r <= a_step;
        b_r <= b_step;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = last_pixel_r;
  assign out_tdata  = OUT_W'({pixel_gray_r, pixel_y_r, pixel_x_r});

  a_major_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (a_r <= amax_r))
    else $error("major axis ran past its end");

  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (load && last) |=> (state_r == ST_IDLE) && out_tvalid && out_tlast)
    else $error("last pixel did not close the line");

  a_major_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !last) |=> (a_r == $past(a_r) + CB'(1)) && !out_tlast)
    else $error("major axis did not advance by one");

  a_no_request_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> !in_tready)
    else $error("request accepted while drawing");

  a_minor_one_way: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> !(move.inc && move.dec))
    else $error("minor axis moved both ways");

endmodule

/* hdl/lrast_step.sv */
module lrast_step
  import lrast_pkg::*;
#(
  parameter int CW = 6,
  parameter int DW = 10
) (
  input  logic signed [DW-1:0] d_i,
  input  logic signed [DW-1:0] inc_lo_i,
  input  logic signed [DW-1:0] inc_hi_i,
  input  logic                 pos_i,
  input  logic        [CW-1:0] major_i,
  input  logic        [CW-1:0] minor_i,
  output logic signed [DW-1:0] d_o,
  output logic        [CW-1:0] major_o,
  output logic        [CW-1:0] minor_o,
  output lrast_move_t          move_o
);

  logic le;

  assign le = (d_i <= 0);
  assign d_o = d_i + (le ? inc_lo_i : inc_hi_i);
  assign major_o = major_i + CW'(1);
  assign move_o.inc = pos_i && !le;
  assign move_o.dec = !pos_i && le;

  always_comb begin
    minor_o = minor_i;
    if (move_o.inc) begin
      minor_o = minor_i + CW'(1);
    end else if (move_o.dec) begin
      minor_o = minor_i - CW'(1);
    end
  end

endmodule
